FILE: src/clsr_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and the modular fold for the combined generator
package clsr_pkg;

    localparam int unsigned PROD_W = 47;

    localparam logic [31:0] MOD_ONE   = 32'd2147483563;
    localparam logic [31:0] MOD_TWO   = 32'd2147483399;
    localparam logic [15:0] MUL_ONE   = 16'd40014;
    localparam logic [15:0] MUL_TWO   = 16'd40692;
    // 2^31 minus each modulus
    localparam logic [7:0]  FOLD_ONE  = 8'd85;
    localparam logic [7:0]  FOLD_TWO  = 8'd249;
    localparam logic [30:0] SEED_ONE  = 31'd1;
    localparam logic [30:0] SEED_TWO  = 31'd123456789;
    localparam logic [30:0] RANGE_TOP = 31'd2147483562;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WMUL = 7'b0000010,
        ST_WRED = 7'b0000100,
        ST_DMUL = 7'b0001000,
        ST_DRED = 7'b0010000,
        ST_DSEL = 7'b0100000,
        ST_DMIX = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic warm_mul;
        logic warm_red;
        logic draw_mul;
        logic draw_red;
        logic draw_sel;
        logic draw_mix;
    } cmd_t;

    typedef struct packed {
        logic warm_done;
    } status_t;

    // product mod (2^31 - fold): fold the high part down, then one subtract
    function automatic logic [30:0] mod_reduce(input logic [PROD_W-1:0] p,
                                               input logic [7:0]        fold,
                                               input logic [31:0]       modv);
        logic [15:0] hi;
        logic [30:0] lo;
        logic [23:0] hf;
        logic [31:0] s;
        logic [31:0] r;
        hi = p[PROD_W-1:31];
        lo = p[30:0];
        hf = 24'(hi) * 24'(fold);
        s  = {1'b0, lo} + {8'b0, hf};
        r  = (s >= modv) ? (s - modv) : s;
        return r[30:0];
    endfunction

endpackage

FILE: src/clsr_ctrl.sv
`timescale 1ns / 1ps
// sequencer for warm-up and draw steps, plus the result valid flag
module clsr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    output logic              m_valid,
    input  logic              m_ready,
    output clsr_pkg::cmd_t    cmd,
    input  clsr_pkg::status_t status
);
    import clsr_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation) begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_WMUL;
                    end else begin
                        state_next = ST_DMUL;
                    end
                end
            end
            ST_WMUL: begin
                cmd.warm_mul = 1'b1;
                state_next   = ST_WRED;
            end
            ST_WRED: begin
                cmd.warm_red = 1'b1;
                state_next   = status.warm_done ? ST_DMUL : ST_WMUL;
            end
            ST_DMUL: begin
                cmd.draw_mul = 1'b1;
                state_next   = ST_DRED;
            end
            ST_DRED: begin
                cmd.draw_red = 1'b1;
                state_next   = ST_DSEL;
            end
            ST_DSEL: begin
                cmd.draw_sel = 1'b1;
                state_next   = ST_DMIX;
            end
            ST_DMIX: begin
                // hold until the previous result has been taken
                if (out_free) begin
                    cmd.draw_mix = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.draw_mix) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: src/clsr_dp.sv
`timescale 1ns / 1ps
// generators, modular multipliers, slot selection and the shuffle table
module clsr_dp #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [30:0]       s_seed_value,
    output logic [30:0]       m_random_value,
    input  clsr_pkg::cmd_t    cmd,
    output clsr_pkg::status_t status
);
    import clsr_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned RW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483562 / TABLE_DEPTH;
    localparam longint unsigned RECIP    = (64'd1 << 31) / SLOT_DIV;
    localparam logic [30:0]   SLOT_DIV_W = 31'(SLOT_DIV);
    localparam logic [RW-1:0] RECIP_W    = RW'(RECIP);
    localparam logic [CW-1:0] WARM_TOP   = CW'(TABLE_DEPTH + 7);
    localparam logic [CW-1:0] DEPTH_C    = CW'(TABLE_DEPTH);
    localparam logic [RW-1:0] DEPTH_R    = RW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_DEPTH - 1);

    logic [30:0]        gen1_reg, gen1_next;
    logic [30:0]        gen2_reg, gen2_next;
    logic [30:0]        last_reg, last_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic [PROD_W-1:0]  prod1_reg, prod2_reg;
    logic [RW-1:0]      qest_reg;
    logic [30:0]        qd_reg;
    logic [IW-1:0]      slot_reg;
    logic [30:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic [30:0]        out_reg;
    logic [30:0]        tbl_mem [TABLE_DEPTH];

    logic [30:0]        red1, red2;
    logic [30+RW:0]     qest_prod;
    logic [30+RW:0]     qd_prod;
    logic [30:0]        rem;
    logic [RW-1:0]      slot_wide;
    logic [IW-1:0]      slot;
    logic [30:0]        rd_val;
    logic [32:0]        diff;
    logic [32:0]        mix;
    logic               warm_wr;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [30:0]        wr_data;

    assign red1 = mod_reduce(prod1_reg, FOLD_ONE, MOD_ONE);
    assign red2 = mod_reduce(prod2_reg, FOLD_TWO, MOD_TWO);

    assign status.warm_done = (cnt_reg == '0);

    // slot = last / SLOT_DIV: reciprocal estimate is low by at most one
    assign qest_prod = (31 + RW)'(last_reg) * (31 + RW)'(RECIP_W);
    assign qd_prod   = (31 + RW)'(qest_reg) * (31 + RW)'(SLOT_DIV_W);
    assign rem       = last_reg - qd_reg;
    assign slot_wide = qest_reg + RW'(rem >= SLOT_DIV_W);
    assign slot      = (slot_wide >= DEPTH_R) ? LAST_SLOT : slot_wide[IW-1:0];

    // never-written entries read as zero
    assign rd_val = rd_valid_reg ? rd_data_reg : '0;
    assign diff   = {2'b00, rd_val} - {2'b00, gen2_reg};
    assign mix    = (diff[32] || diff == '0) ? (diff + {2'b00, RANGE_TOP}) : diff;

    assign warm_wr = cmd.warm_red && (cnt_reg < DEPTH_C);
    assign wr_en   = warm_wr || cmd.draw_mix;
    assign wr_addr = cmd.draw_mix ? slot_reg : cnt_reg[IW-1:0];
    assign wr_data = cmd.draw_mix ? gen1_reg : red1;

    assign m_random_value = out_reg;

    always_comb begin
        gen1_next  = gen1_reg;
        gen2_next  = gen2_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (cmd.load_seed) begin
            gen1_next = (s_seed_value == '0) ? SEED_ONE : s_seed_value;
            gen2_next = (s_seed_value == '0) ? SEED_ONE : s_seed_value;
            cnt_next  = WARM_TOP;
        end
        if (cmd.warm_red) begin
            gen1_next = red1;
            if (cnt_reg == '0) begin
                last_next = red1;
            end else begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
        if (cmd.draw_red) begin
            gen1_next = red1;
            gen2_next = red2;
        end
        if (cmd.draw_mix) begin
            last_next = mix[30:0];
        end
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen1_reg  <= SEED_ONE;
            gen2_reg  <= SEED_TWO;
            last_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= '0;
        end else begin
            gen1_reg  <= gen1_next;
            gen2_reg  <= gen2_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.warm_mul || cmd.draw_mul) begin
            prod1_reg <= PROD_W'(gen1_reg) * PROD_W'(MUL_ONE);
        end
        if (cmd.draw_mul) begin
            prod2_reg <= PROD_W'(gen2_reg) * PROD_W'(MUL_TWO);
            qest_reg  <= qest_prod[30+RW:31];
        end
        if (cmd.draw_red) begin
            qd_reg <= qd_prod[30:0];
        end
        if (cmd.draw_sel) begin
            slot_reg     <= slot;
            rd_valid_reg <= valid_reg[slot];
        end
        if (cmd.draw_mix) begin
            out_reg <= mix[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (cmd.draw_sel) begin
            rd_data_reg <= tbl_mem[slot];
        end
    end

endmodule

FILE: src/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
// top level: combined congruential generator with shuffle table
//
//  channel | direction | ports                                   | transfer
//  s_      | in        | s_operation, s_seed_value               | s_valid & s_ready
//  m_      | out       | m_random_value                          | m_valid & m_ready
//
// a draw steps through idle with transfer, multiply, modular fold, slot select and mix
// the result is registered and flagged valid by the mix step
// a reseed first runs warm-up steps, one multiply and one fold per warm-up step
// both generators share one sequencer; an item is taken only when it is idle
// reset clears generators to their start values and marks every table slot empty
// a result waiting on m_ready holds the final mix step of the next item
module combined_lcg_shuffle_rng #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [30:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_random_value
);
    import clsr_pkg::*;

    cmd_t    cmd;
    status_t status;

    clsr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    clsr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_seed_value   (s_seed_value),
        .m_random_value (m_random_value),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

FILE: src/clsr_checker.sv
`timescale 1ns / 1ps
// port-level checks for the generator, bound to the top level
module clsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic [30:0] s_seed_value,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_random_value
);

    // a result waits until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value))
        else $error("result dropped or changed while stalled");

    // results stay in 1..2147483562
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_random_value != 31'd0) && (m_random_value <= 31'd2147483562))
        else $error("result out of range");

    // a transfer on the input keeps the block busy for the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while still busy");

    // a waiting request keeps its payload until the transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_operation) && $stable(s_seed_value))
        else $error("request dropped or changed while waiting");

    // no result can appear right out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);
